@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file of this project.
// Needs nothing else; pulled in by `include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, disabled while the given reset is high.
`define PECQ_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: assertion failed");

// Concurrent assertion that is also checked during reset.
`define PECQ_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("%m: assertion failed");

`endif

@@ rtl/pecq_pkg.sv @@
// Package for the position error clear qualifier.
// Holds register codes, indexes and the configuration struct; no dependencies.
`default_nettype none

package pecq_pkg;

   localparam int unsigned LIMIT_W = 16;
   localparam int unsigned COUNT_W = LIMIT_W + 1;

   localparam logic [1:0] SEL_LEVEL     = 2'd0;
   localparam logic [1:0] SEL_RISE      = 2'd1;
   localparam logic [1:0] SEL_INV_LEVEL = 2'd2;
   localparam logic [1:0] SEL_FALL      = 2'd3;

   localparam logic [1:0] MODE_FULL     = 2'd0;
   localparam logic [1:0] MODE_SIGNAL   = 2'd1;
   localparam logic [1:0] MODE_ALARM    = 2'd2;
   localparam logic [1:0] MODE_OFF      = 2'd3;

   localparam logic [1:0] REG_SIGNAL_SELECT = 2'd0;
   localparam logic [1:0] REG_OT_ENABLE     = 2'd1;
   localparam logic [1:0] REG_CLEAR_MODE    = 2'd2;
   localparam logic [1:0] REG_DELAY_LIMIT   = 2'd3;

   localparam logic [LIMIT_W-1:0] DELAY_LIMIT_RESET = 16'd80;

   localparam logic [1:0] HIST_RISE = 2'b01;
   localparam logic [1:0] HIST_FALL = 2'b10;

   typedef struct packed {
      logic [1:0]         signal_select;
      logic               ot_enable;
      logic [1:0]         clear_mode;
      logic [LIMIT_W-1:0] delay_limit;
   } cfg_type;

endpackage

`default_nettype wire

@@ rtl/pecq_qualify.sv @@
// Per-tick clear qualification: edge select, overtravel rule, clear mode.
// Holds the history and alarm delay state; uses pecq_pkg.
`default_nettype none

module pecq_qualify import pecq_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               accept,
   input  wire cfg_type            cfg,
   input  wire logic               clear_input,
   input  wire logic               pos_limit,
   input  wire logic               neg_limit,
   input  wire logic signed [31:0] position_error,
   input  wire logic               alarm_active,
   input  wire logic               ref_clear_request,
   output logic                    clear_signal,
   output logic                    clear_command
);

   logic [1:0]         clear_hist_ff, clear_hist_in;
   logic [1:0]         limit_hist_ff, limit_hist_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               err_neg, err_pos, count_over, toward_limit;
   logic               sig;

   assign clear_hist_in = {clear_hist_ff[0], clear_input};
   assign err_neg       = position_error[31];
   assign err_pos       = !position_error[31] && (position_error != '0);
   assign toward_limit  = (pos_limit && err_pos) || (neg_limit && err_neg);
   assign count_over    = count_ff > {1'b0, cfg.delay_limit};

   always_comb begin
      case (cfg.signal_select)
         SEL_LEVEL:     sig = clear_input;
         SEL_RISE:      sig = (clear_hist_in == HIST_RISE);
         SEL_FALL:      sig = (clear_hist_in == HIST_FALL);
         SEL_INV_LEVEL: sig = !clear_input;
         default:       sig = !clear_input;
      endcase

      limit_hist_in = limit_hist_ff;
      if (cfg.ot_enable) begin
         limit_hist_in = {limit_hist_ff[0], pos_limit | neg_limit};
         if (limit_hist_in == HIST_RISE) begin
            if (toward_limit) begin
               sig = 1'b1;
            end
         end else begin
            sig = 1'b0;
         end
      end
      clear_signal = sig;

      count_in      = count_ff;
      clear_command = sig;
      case (cfg.clear_mode) inside
         MODE_FULL, MODE_ALARM: begin
            if (alarm_active) begin
               if (count_over) begin
                  clear_command = 1'b1;
               end else begin
                  count_in = count_ff + 1'b1;
               end
            end else begin
               count_in = '0;
               if (cfg.clear_mode == MODE_FULL && ref_clear_request) begin
                  clear_command = 1'b1;
               end
            end
         end
         MODE_SIGNAL: clear_command = sig;
         MODE_OFF:    clear_command = 1'b0;
         default:     clear_command = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_hist_ff <= '0;
         limit_hist_ff <= '0;
         count_ff      <= '0;
      end else if (accept) begin
         clear_hist_ff <= clear_hist_in;
         limit_hist_ff <= limit_hist_in;
         count_ff      <= count_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/position_error_clear_qualifier.sv @@
// Top level of the position error clear qualifier: CSRs and result register.
// Uses pecq_pkg and pecq_qualify.
//
// One word in per servo scan tick, one word out. A word is taken in any cycle
// in which the result register is empty or its word is taken in the same
// cycle, so the block sustains one word per clock; the result appears in the
// cycle after acceptance, from the single result register. CSR writes are
// always ready and take effect on the next word.
`default_nettype none

module position_error_clear_qualifier import pecq_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_clear_input,
   input  wire logic               req_pos_limit,
   input  wire logic               req_neg_limit,
   input  wire logic signed [31:0] req_position_error,
   input  wire logic               req_alarm_active,
   input  wire logic               req_ref_clear_request,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic                    rsp_clear_signal,
   output logic                    rsp_clear_command,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [1:0]         csr_index,
   input  wire logic [LIMIT_W-1:0] csr_wdata
);

   cfg_type cfg_ff;
   logic    valid_ff;
   logic    sig_ff, cmd_ff;
   logic    accept, sig, cmd;

   assign csr_ready = 1'b1;
   assign req_stall = valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.signal_select <= SEL_LEVEL;
         cfg_ff.ot_enable     <= 1'b0;
         cfg_ff.clear_mode    <= MODE_FULL;
         cfg_ff.delay_limit   <= DELAY_LIMIT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_SIGNAL_SELECT: cfg_ff.signal_select <= csr_wdata[1:0];
            REG_OT_ENABLE:     cfg_ff.ot_enable     <= csr_wdata[0];
            REG_CLEAR_MODE:    cfg_ff.clear_mode    <= csr_wdata[1:0];
            REG_DELAY_LIMIT:   cfg_ff.delay_limit   <= csr_wdata;
            default: ;
         endcase
      end
   end

   pecq_qualify u_qualify (
      .clock             (clock),
      .reset             (reset),
      .accept            (accept),
      .cfg               (cfg_ff),
      .clear_input       (req_clear_input),
      .pos_limit         (req_pos_limit),
      .neg_limit         (req_neg_limit),
      .position_error    (req_position_error),
      .alarm_active      (req_alarm_active),
      .ref_clear_request (req_ref_clear_request),
      .clear_signal      (sig),
      .clear_command     (cmd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!req_stall) begin
         valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         sig_ff <= sig;
         cmd_ff <= cmd;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_clear_signal  = sig_ff;
   assign rsp_clear_command = cmd_ff;

endmodule

`default_nettype wire

@@ rtl/pecq_checker.sv @@
// Port-level checker for position_error_clear_qualifier, with its bind.
// Uses assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module pecq_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_stall,
   input wire logic rsp_valid,
   input wire logic rsp_stall,
   input wire logic rsp_clear_signal,
   input wire logic rsp_clear_command
);

   // accepted word shows up as a result next cycle
   `PECQ_ASSERT(a_accept_to_rsp, clock, reset, req_valid && !req_stall |=> rsp_valid)
   // a held result blocks new words
   `PECQ_ASSERT(a_full_stalls, clock, reset, rsp_valid && rsp_stall |-> req_stall)
   `PECQ_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_clear_signal) && $stable(rsp_clear_command))
   `PECQ_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid)

endmodule

bind position_error_clear_qualifier pecq_checker u_pecq_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_clear_signal  (rsp_clear_signal),
   .rsp_clear_command (rsp_clear_command)
);

`default_nettype wire

@@ sim/tb_top.sv @@
// Self-checking testbench for position_error_clear_qualifier.
// Needs pecq_pkg and the block's RTL; predicts each result word and checks it in order.
`timescale 1ns / 1ps

module tb_top;
   import pecq_pkg::*;

   localparam int unsigned QUIET_LIMIT = 2000;
   localparam int unsigned IDLE_PCT    = 26;
   localparam int unsigned HOLD_CYCLES = 120;

   typedef struct packed {
      logic               clear_in;
      logic               pos_lim;
      logic               neg_lim;
      logic signed [31:0] pos_err;
      logic               alarm;
      logic               ref_req;
   } tick_type;

   typedef struct packed {
      logic sig;
      logic cmd;
   } clear_type;

   logic               clock;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_clear_input = 1'b0;
   logic               req_pos_limit = 1'b0;
   logic               req_neg_limit = 1'b0;
   logic signed [31:0] req_position_error = '0;
   logic               req_alarm_active = 1'b0;
   logic               req_ref_clear_request = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_clear_signal;
   logic               rsp_clear_command;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [1:0]         csr_index = '0;
   logic [LIMIT_W-1:0] csr_wdata = '0;

   position_error_clear_qualifier dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_clear_input       (req_clear_input),
      .req_pos_limit         (req_pos_limit),
      .req_neg_limit         (req_neg_limit),
      .req_position_error    (req_position_error),
      .req_alarm_active      (req_alarm_active),
      .req_ref_clear_request (req_ref_clear_request),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_clear_signal      (rsp_clear_signal),
      .rsp_clear_command     (rsp_clear_command),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   tick_type  pending_ticks[$];
   clear_type expected_clears[$];

   cfg_type            cfg_shadow;
   logic [1:0]         clear_hist;
   logic [1:0]         limit_hist;
   logic [COUNT_W-1:0] alarm_count;

   int unsigned failures = 0;
   int unsigned quiet_cycles = 0;
   bit          calm = 1'b0;
   bit          hold_req = 1'b0;
   bit          hold_done = 1'b0;
   int unsigned hold_left = 0;

   // stimulus levels carried between random ticks
   logic lv_clear = 1'b0;
   logic lv_pos = 1'b0;
   logic lv_neg = 1'b0;
   logic lv_alarm = 1'b0;

   tick_type  next_tick;
   tick_type  taken_tick;
   clear_type got_clear;
   clear_type want_clear;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
   end

   function automatic clear_type qualify_tick(input tick_type t);
      clear_type r;
      logic      err_neg;
      logic      err_pos;
      err_neg = t.pos_err[31];
      err_pos = !t.pos_err[31] && (t.pos_err != 0);
      clear_hist = {clear_hist[0], t.clear_in};
      case (cfg_shadow.signal_select)
         SEL_LEVEL: r.sig = t.clear_in;
         SEL_RISE:  r.sig = (clear_hist == HIST_RISE);
         SEL_FALL:  r.sig = (clear_hist == HIST_FALL);
         default:   r.sig = !t.clear_in;
      endcase
      if (cfg_shadow.ot_enable) begin
         limit_hist = {limit_hist[0], t.pos_lim | t.neg_lim};
         if (limit_hist == HIST_RISE) begin
            if ((t.pos_lim && err_pos) || (t.neg_lim && err_neg)) r.sig = 1'b1;
         end else begin
            r.sig = 1'b0;
         end
      end
      case (cfg_shadow.clear_mode)
         MODE_FULL, MODE_ALARM: begin
            if (t.alarm) begin
               if (alarm_count > {1'b0, cfg_shadow.delay_limit}) begin
                  r.cmd = 1'b1;
               end else begin
                  alarm_count = alarm_count + 1'b1;
                  r.cmd = r.sig;
               end
            end else begin
               r.cmd = r.sig | (cfg_shadow.clear_mode == MODE_FULL && t.ref_req);
               alarm_count = '0;
            end
         end
         MODE_SIGNAL: r.cmd = r.sig;
         default:     r.cmd = 1'b0;
      endcase
      return r;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            taken_tick = '{req_clear_input, req_pos_limit, req_neg_limit,
                           req_position_error, req_alarm_active, req_ref_clear_request};
            expected_clears.push_back(qualify_tick(taken_tick));
         end
         if (!req_valid || !req_stall) begin
            if (pending_ticks.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
               next_tick = pending_ticks.pop_front();
               req_valid             <= 1'b1;
               req_clear_input       <= next_tick.clear_in;
               req_pos_limit         <= next_tick.pos_lim;
               req_neg_limit         <= next_tick.neg_lim;
               req_position_error    <= next_tick.pos_err;
               req_alarm_active      <= next_tick.alarm;
               req_ref_clear_request <= next_tick.ref_req;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor and receiver
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got_clear = '{rsp_clear_signal, rsp_clear_command};
            if (expected_clears.size() == 0) begin
               $error("result word with none expected: clear_signal=%0b clear_command=%0b",
                      got_clear.sig, got_clear.cmd);
               failures++;
            end else begin
               want_clear = expected_clears.pop_front();
               if (got_clear.sig !== want_clear.sig) begin
                  $error("clear_signal: expected %0b, got %0b", want_clear.sig, got_clear.sig);
                  failures++;
               end
               if (got_clear.cmd !== want_clear.cmd) begin
                  $error("clear_command: expected %0b, got %0b", want_clear.cmd, got_clear.cmd);
                  failures++;
               end
            end
         end
         if (hold_req && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left != 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb_top failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic write_reg(input logic [1:0] idx, input logic [LIMIT_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         REG_SIGNAL_SELECT: cfg_shadow.signal_select = data[1:0];
         REG_OT_ENABLE:     cfg_shadow.ot_enable     = data[0];
         REG_CLEAR_MODE:    cfg_shadow.clear_mode    = data[1:0];
         default:           cfg_shadow.delay_limit   = data;
      endcase
   endtask

   // narrow registers get random upper bits, which the block must ignore
   task automatic set_config(input logic [1:0] sel, input logic ot, input logic [1:0] mode,
                             input logic [LIMIT_W-1:0] lim);
      logic [LIMIT_W-1:0] wd;
      wd = LIMIT_W'($urandom());
      wd[1:0] = sel;
      write_reg(REG_SIGNAL_SELECT, wd);
      wd = LIMIT_W'($urandom());
      wd[0] = ot;
      write_reg(REG_OT_ENABLE, wd);
      wd = LIMIT_W'($urandom());
      wd[1:0] = mode;
      write_reg(REG_CLEAR_MODE, wd);
      write_reg(REG_DELAY_LIMIT, lim);
   endtask

   function automatic void add_tick(input logic c, input logic p, input logic n,
                                    input logic [31:0] e, input logic a, input logic r);
      pending_ticks.push_back('{c, p, n, e, a, r});
   endfunction

   task automatic drain;
      while (pending_ticks.size() != 0 || req_valid || expected_clears.size() != 0)
         @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic queue_random(input int unsigned count);
      logic [31:0] err;
      int unsigned k;
      repeat (count) begin
         if ($urandom_range(0, 99) < 30) lv_clear = !lv_clear;
         if ($urandom_range(0, 99) < 15) lv_pos = !lv_pos;
         if ($urandom_range(0, 99) < 15) lv_neg = !lv_neg;
         if ($urandom_range(0, 99) < 8)  lv_alarm = !lv_alarm;
         k = $urandom_range(0, 9);
         if (k == 0) begin
            err = '0;
         end else if (k == 1) begin
            err = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
         end else if (k < 6) begin
            err = $urandom_range(1, 1000);
            if ($urandom_range(0, 1)) err = -err;
         end else begin
            err = $urandom();
         end
         add_tick(lv_clear, lv_pos, lv_neg, err, lv_alarm, $urandom_range(0, 99) < 25);
      end
   endtask

   function automatic logic [LIMIT_W-1:0] pick_limit();
      int unsigned k;
      k = $urandom_range(0, 9);
      if (k == 0) return '0;
      if (k == 1) return '1;
      if (k == 2) return LIMIT_W'($urandom());
      return LIMIT_W'($urandom_range(1, 16));
   endfunction

   initial begin
      cfg_shadow  = '{SEL_LEVEL, 1'b0, MODE_FULL, DELAY_LIMIT_RESET};
      clear_hist  = '0;
      limit_hist  = '0;
      alarm_count = '0;
      @(posedge clock);
      while (reset) @(posedge clock);

      // reset settings: level select, full mode
      add_tick(0, 0, 0, 32'h0000_0000, 0, 0);
      add_tick(1, 1, 1, 32'h7FFF_FFFF, 0, 0);
      add_tick(0, 0, 0, 32'h8000_0000, 0, 1);
      add_tick(1, 0, 0, 32'hFFFF_FFFF, 1, 0);
      add_tick(0, 0, 0, 32'h0000_0001, 0, 0);
      drain();

      // overtravel edges: direction mismatch, match, zero error, held switch
      set_config(SEL_RISE, 1'b1, MODE_SIGNAL, DELAY_LIMIT_RESET);
      add_tick(0, 0, 0, 32'h0000_0000, 0, 0);
      add_tick(1, 1, 0, -32'sd5, 0, 0);
      add_tick(0, 0, 0, 32'h0000_0000, 0, 0);
      add_tick(0, 1, 0, 32'd100, 0, 0);
      add_tick(0, 0, 0, 32'h0000_0000, 0, 0);
      add_tick(0, 0, 1, -32'sd100, 0, 0);
      add_tick(0, 0, 0, 32'h0000_0000, 0, 0);
      add_tick(0, 1, 1, 32'h0000_0000, 0, 0);
      add_tick(1, 1, 1, 32'h8000_0000, 0, 0);
      drain();

      // alarm counter ceiling at zero limit
      set_config(SEL_FALL, 1'b0, MODE_ALARM, '0);
      add_tick(1, 0, 0, 32'h0000_0000, 1, 0);
      add_tick(0, 0, 0, 32'h0000_0000, 1, 0);
      add_tick(0, 0, 0, 32'h0000_0000, 1, 1);
      add_tick(0, 0, 0, 32'h0000_0000, 0, 0);
      add_tick(1, 0, 0, 32'h0000_0000, 1, 0);
      drain();

      // counter left alone in signal-only and off modes
      set_config(SEL_INV_LEVEL, 1'b0, MODE_SIGNAL, 16'd1);
      add_tick(0, 0, 0, 32'h0000_0000, 1, 1);
      add_tick(1, 0, 0, 32'h0000_0000, 1, 1);
      drain();
      set_config(SEL_LEVEL, 1'b0, MODE_OFF, '1);
      add_tick(1, 1, 0, 32'h7FFF_FFFF, 1, 1);
      add_tick(1, 0, 1, 32'h8000_0000, 0, 1);
      drain();
      set_config(SEL_LEVEL, 1'b0, MODE_FULL, 16'd1);
      add_tick(0, 0, 0, 32'h0000_0000, 1, 0);
      add_tick(0, 0, 0, 32'h0000_0000, 1, 0);
      add_tick(1, 0, 0, 32'h0000_0000, 1, 0);
      drain();

      for (int ph = 0; ph < 10; ph++) begin
         set_config(2'($urandom()), 1'($urandom()), 2'($urandom()), pick_limit());
         calm = (ph == 3);
         hold_req = (ph == 6);
         queue_random(72);
         drain();
      end
      calm = 1'b0;

      repeat (4) @(posedge clock);
      if (failures == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/pecq_pkg.sv
rtl/pecq_qualify.sv
rtl/position_error_clear_qualifier.sv
rtl/pecq_checker.sv
sim/tb_top.sv
